@@ rtl/bsfr_pkg.sv @@
// Shared types and constants for the byte-stuffed frame receiver.
package bsfr_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 512;
   localparam int unsigned COUNT_WIDTH     = 10;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLAG_VALUE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_VALUE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRC_POLYNOMIAL = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRC_START      = 2'd3;

   localparam logic [7:0]  FLAG_RESET   = 8'h7E;
   localparam logic [7:0]  ESCAPE_RESET = 8'h7D;
   localparam logic [15:0] POLY_RESET   = 16'hA001;
   localparam logic [15:0] START_RESET  = 16'hFFFF;

   localparam logic [7:0] ESCAPE_XOR = 8'h20;

   // Nonempty frames of this many bytes or fewer are reported as too short
   localparam logic [COUNT_WIDTH-1:0] SHORT_LIMIT = COUNT_WIDTH'(6);
   // Depth of the delay line that hides the trailing CRC
   localparam logic [COUNT_WIDTH-1:0] HOLD_DEPTH  = COUNT_WIDTH'(2);
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = COUNT_WIDTH'(MAX_FRAME_BYTES);

   typedef enum logic [2:0] {
      KIND_PAYLOAD   = 3'd0,
      KIND_OK        = 3'd1,
      KIND_CRC_ERROR = 3'd2,
      KIND_TOO_LONG  = 3'd3,
      KIND_TOO_SHORT = 3'd4
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] payload;
   } result_type;

endpackage

@@ rtl/bsfr_crc16.sv @@
// Reflected CRC-16 update over one byte, unrolled over its eight bits.
module bsfr_crc16 (
   input  logic [15:0] crc_i,
   input  logic [7:0]  data_i,
   input  logic [15:0] poly_i,
   output logic [15:0] crc_o
);

   always_comb begin
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly_i;
         end else begin
            c = c >> 1;
         end
      end
      crc_o = c;
   end

endmodule

@@ rtl/bsfr_deframer.sv @@
// Frame state, unstuffing, delay line, CRC check and control registers.
module bsfr_deframer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bsfr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                 step,
   input  logic [7:0]                           rx_byte,
   output bsfr_pkg::result_type                 result
);
   import bsfr_pkg::*;

   logic [7:0]             flag_ff, flag_in;
   logic [7:0]             escape_ff, escape_in;
   logic [15:0]            poly_ff, poly_in;
   logic [15:0]            start_ff, start_in;

   logic                   in_frame_ff, in_frame_in;
   logic                   esc_pending_ff, esc_pending_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [7:0]             held_ff [2];
   logic [7:0]             held_in [2];
   logic [15:0]            crc_ff, crc_in;
   logic [15:0]            crc_next;

   bsfr_crc16 u_crc (
      .crc_i  (crc_ff),
      .data_i (held_ff[0]),
      .poly_i (poly_ff),
      .crc_o  (crc_next)
   );

   always_comb begin
      flag_in   = flag_ff;
      escape_in = escape_ff;
      poly_in   = poly_ff;
      start_in  = start_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FLAG_VALUE:     flag_in   = csr_wdata[7:0];
            CSR_ESCAPE_VALUE:   escape_in = csr_wdata[7:0];
            CSR_CRC_POLYNOMIAL: poly_in   = csr_wdata;
            CSR_CRC_START:      start_in  = csr_wdata;
            default:            ;
         endcase
      end
   end

   always_comb begin
      logic [7:0] b;
      in_frame_in    = in_frame_ff;
      esc_pending_in = esc_pending_ff;
      count_in       = count_ff;
      held_in[0]     = held_ff[0];
      held_in[1]     = held_ff[1];
      crc_in         = crc_ff;
      result         = '{valid: 1'b0, kind: KIND_PAYLOAD, payload: 8'h00};
      b              = esc_pending_ff ? (rx_byte ^ ESCAPE_XOR) : rx_byte;

      if (step) begin
         if (rx_byte == flag_ff) begin
            if (in_frame_ff && count_ff > SHORT_LIMIT) begin
               result.valid = 1'b1;
               result.kind  = (crc_ff == {held_ff[1], held_ff[0]}) ? KIND_OK : KIND_CRC_ERROR;
               in_frame_in  = 1'b0;
            end else begin
               if (in_frame_ff && count_ff != '0) begin
                  result.valid = 1'b1;
                  result.kind  = KIND_TOO_SHORT;
               end
               in_frame_in = 1'b1;
            end
            esc_pending_in = 1'b0;
            count_in       = '0;
            held_in[0]     = 8'h00;
            held_in[1]     = 8'h00;
            crc_in         = start_ff;
         end else if (in_frame_ff) begin
            if (rx_byte == escape_ff) begin
               esc_pending_in = 1'b1;
            end else if (count_ff >= COUNT_LIMIT) begin
               result.valid   = 1'b1;
               result.kind    = KIND_TOO_LONG;
               in_frame_in    = 1'b0;
               esc_pending_in = 1'b0;
               count_in       = '0;
               held_in[0]     = 8'h00;
               held_in[1]     = 8'h00;
               crc_in         = start_ff;
            end else begin
               // oldest held byte leaves the delay line as payload
               if (count_ff >= HOLD_DEPTH) begin
                  result.valid   = 1'b1;
                  result.kind    = KIND_PAYLOAD;
                  result.payload = held_ff[0];
                  crc_in         = crc_next;
               end
               esc_pending_in = 1'b0;
               held_in[0]     = held_ff[1];
               held_in[1]     = b;
               count_in       = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff        <= FLAG_RESET;
         escape_ff      <= ESCAPE_RESET;
         poly_ff        <= POLY_RESET;
         start_ff       <= START_RESET;
         in_frame_ff    <= 1'b0;
         esc_pending_ff <= 1'b0;
         count_ff       <= '0;
         held_ff[0]     <= 8'h00;
         held_ff[1]     <= 8'h00;
         crc_ff         <= START_RESET;
      end else begin
         flag_ff        <= flag_in;
         escape_ff      <= escape_in;
         poly_ff        <= poly_in;
         start_ff       <= start_in;
         in_frame_ff    <= in_frame_in;
         esc_pending_ff <= esc_pending_in;
         count_ff       <= count_in;
         held_ff[0]     <= held_in[0];
         held_ff[1]     <= held_in[1];
         crc_ff         <= crc_in;
      end
   end

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> count_ff == '0)
      else $error("byte count not cleared outside a frame");

   a_idle_no_escape: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> !esc_pending_ff)
      else $error("escape pending outside a frame");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("byte count beyond frame limit");

   a_payload_in_frame: assert property (@(posedge clock) disable iff (reset)
      step && result.valid && result.kind == KIND_PAYLOAD |=> in_frame_ff && count_ff > HOLD_DEPTH)
      else $error("payload beat emitted outside a frame");

endmodule

@@ rtl/byte_stuffed_frame_receiver.sv @@
// Top level: input register, deframer and result register with handshakes.
//
//  channel  dir  ports                          contents
//  req      in   req_tvalid/tready/tdata        tdata[7:0] rx_byte
//  rsp      out  rsp_tvalid/tready/tdata/tuser  tdata[7:0] payload, tuser[2:0] kind
//  csr      in   csr_wr_en/index/wdata          flag, escape, polynomial, crc start
//
// One beat per cycle sustained while the result side is ready; whatever a beat causes is
// registered through the input register, then deframer logic into the result register.
// A payload byte leaves when the second byte after it arrives (two-byte delay line).
// The CRC is a single-byte unrolled update, registered in the deframer.
// Synchronous active-high reset; control registers back to their defaults.
// A stalled result holds the deframer and the input register; a new beat is still taken
// whenever the input register is empty or its byte can move on in the same cycle.
module byte_stuffed_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] rx_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] payload
   output logic [2:0]                           rsp_tuser,   // [2:0] kind
   input  logic                                 csr_wr_en,
   input  logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bsfr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bsfr_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   kind_type   out_kind_ff, out_kind_in;
   logic [7:0] out_data_ff, out_data_in;
   logic       advance;
   result_type result;

   bsfr_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .result    (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
      if (advance && result.valid) begin
         out_valid_in = 1'b1;
         out_kind_in  = result.kind;
         out_data_in  = result.payload;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

endmodule

@@ tb/byte_stuffed_frame_receiver_test.sv @@
// Self-checking testbench for the byte-stuffed frame receiver: framed traffic against a predictor.
module byte_stuffed_frame_receiver_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bsfr_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 2000;
   localparam int PRINT_CAP     = 100;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload;
   } deframed_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = 8'h00;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;
   logic [2:0]                 rsp_tuser;
   logic                       csr_wr_en  = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   // register copies shared by the predictor and the frame builder
   logic [7:0]  cfg_flag;
   logic [7:0]  cfg_escape;
   logic [15:0] cfg_poly;
   logic [15:0] cfg_crc_start;

   // predicted receiver state
   logic                   frame_open;
   logic                   escape_armed;
   logic [COUNT_WIDTH-1:0] frame_bytes;
   logic [7:0]             held [2];
   logic [15:0]            running_crc;

   deframed_type deframed_due [$];
   logic [7:0]   line_bytes [$];
   logic [7:0]   carry_bytes [$];
   logic [7:0]   frame_body [$];

   bit line_beat_taken = 1'b0;
   int line_idle_pct   = 0;
   int rsp_idle_pct    = 0;
   int line_gap_left   = 0;
   int rsp_stall_left  = 0;
   int queued_bytes    = 0;
   int accepted_bytes  = 0;
   int errors          = 0;
   int idle_cycles     = 0;
   int settings_used   = 1;
   int kinds_seen [5]  = '{default: 0};

   byte_stuffed_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] rx_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] payload
      .rsp_tuser  (rsp_tuser),   // [2:0] kind
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b,
                                                input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic void clear_frame();
      escape_armed = 1'b0;
      frame_bytes  = '0;
      held[0]      = 8'h00;
      held[1]      = 8'h00;
      running_crc  = cfg_crc_start;
   endfunction

   function automatic void due_result(input kind_type kind, input logic [7:0] payload);
      deframed_type r;
      r.kind       = kind;
      r.payload    = payload;
      deframed_due = {deframed_due, r};
   endfunction

   // Works out what one accepted line byte yields.
   function automatic void deframe_byte(input logic [7:0] rx);
      logic [7:0] b;
      b = rx;
      if (b == cfg_flag) begin
         if (frame_open && frame_bytes > SHORT_LIMIT) begin
            due_result(({held[1], held[0]} == running_crc) ? KIND_OK : KIND_CRC_ERROR, 8'h00);
            frame_open = 1'b0;
         end else begin
            if (frame_open && frame_bytes != '0) due_result(KIND_TOO_SHORT, 8'h00);
            frame_open = 1'b1;
         end
         clear_frame();
      end else if (frame_open) begin
         if (b == cfg_escape) begin
            escape_armed = 1'b1;
         end else begin
            if (escape_armed) begin
               b            = b ^ ESCAPE_XOR;
               escape_armed = 1'b0;
            end
            if (frame_bytes >= COUNT_LIMIT) begin
               frame_open = 1'b0;
               clear_frame();
               due_result(KIND_TOO_LONG, 8'h00);
            end else begin
               // two-byte delay hides the trailing CRC
               if (frame_bytes >= HOLD_DEPTH) begin
                  running_crc = crc16_update(running_crc, held[0], cfg_poly);
                  due_result(KIND_PAYLOAD, held[0]);
               end
               held[0]     = held[1];
               held[1]     = b;
               frame_bytes = frame_bytes + 1'b1;
            end
         end
      end
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // ---------------- stimulus building ----------------

   function automatic void push_line(input logic [7:0] b);
      line_bytes = {line_bytes, b};
      queued_bytes++;
   endfunction

   function automatic void push_stuffed(input logic [7:0] b);
      if (b == cfg_flag || b == cfg_escape) begin
         push_line(cfg_escape);
         push_line(b ^ ESCAPE_XOR);
      end else begin
         push_line(b);
      end
   endfunction

   // flag, stuffed body, stuffed CRC low then high, flag
   task automatic queue_frame(input bit bad_crc);
      logic [15:0] crc;
      crc = cfg_crc_start;
      push_line(cfg_flag);
      foreach (frame_body[i]) begin
         push_stuffed(frame_body[i]);
         crc = crc16_update(crc, frame_body[i], cfg_poly);
      end
      if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      push_stuffed(crc[7:0]);
      push_stuffed(crc[15:8]);
      push_line(cfg_flag);
   endtask

   task automatic fill_body(input int len);
      logic [7:0] b;
      frame_body.delete();
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 19))
            0:       b = cfg_flag;
            1:       b = cfg_escape;
            default: b = 8'($urandom_range(0, 255));
         endcase
         frame_body = {frame_body, b};
      end
   endtask

   task automatic queue_traffic(input int budget);
      int target;
      int pick;
      int n;
      target = queued_bytes + budget;
      while (queued_bytes < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = $urandom_range(0, 9);
            if (n < 2) fill_body($urandom_range(0, 4));
            else if (n < 9) fill_body($urandom_range(5, 24));
            else fill_body($urandom_range(25, 60));
            queue_frame($urandom_range(0, 9) == 0);
         end else if (pick < 80) begin
            // line noise, mostly ignored between frames
            n = $urandom_range(1, 4);
            repeat (n) push_line(8'($urandom_range(0, 255)));
         end else begin
            // broken frame: raw bytes, stray escapes and flags, no closing flag
            push_line(cfg_flag);
            n = $urandom_range(1, 12);
            repeat (n) begin
               case ($urandom_range(0, 9))
                  0:       push_line(cfg_escape);
                  1:       push_line(cfg_flag);
                  default: push_line(8'($urandom_range(0, 255)));
               endcase
            end
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FLAG_VALUE:     cfg_flag      = value[7:0];
         CSR_ESCAPE_VALUE:   cfg_escape    = value[7:0];
         CSR_CRC_POLYNOMIAL: cfg_poly      = value;
         CSR_CRC_START:      cfg_crc_start = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] flag_v, input logic [7:0] esc_v,
                            input logic [15:0] poly_v, input logic [15:0] start_v);
      write_csr(CSR_FLAG_VALUE, {8'h00, flag_v});
      write_csr(CSR_ESCAPE_VALUE, {8'h00, esc_v});
      write_csr(CSR_CRC_POLYNOMIAL, poly_v);
      write_csr(CSR_CRC_START, start_v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // sender holds off until every due result is in and the pipe has emptied
   task automatic wait_drained();
      do @(negedge clock);
      while (!(line_bytes.size() == 0 && !req_tvalid && deframed_due.size() == 0));
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ---------------- driver, receiver side, monitor ----------------

   always @(negedge clock) begin
      bit taken;
      taken           = line_beat_taken;
      line_beat_taken = 1'b0;
      if (taken) void'(line_bytes.pop_front());
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || taken) begin
         if (line_gap_left > 0) begin
            line_gap_left--;
            req_tvalid <= 1'b0;
         end else if (line_idle_pct > 0 && $urandom_range(0, 99) < line_idle_pct) begin
            line_gap_left = $urandom_range(0, 17);
            req_tvalid <= 1'b0;
         end else if (line_bytes.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= line_bytes[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall_left = $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      deframed_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tuser < 3'd5) kinds_seen[rsp_tuser]++;
            if (deframed_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat kind %0d payload %02h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = deframed_due.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_tuser, want.kind));
               if (rsp_tdata !== want.payload)
                  report_mismatch($sformatf("payload %02h, expected %02h",
                                            rsp_tdata, want.payload));
            end
         end
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
            accepted_bytes++;
            line_beat_taken = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, deframed_due.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- run sequence ----------------

   initial begin
      int mark;
      cfg_flag      = FLAG_RESET;
      cfg_escape    = ESCAPE_RESET;
      cfg_poly      = POLY_RESET;
      cfg_crc_start = START_RESET;
      frame_open    = 1'b0;
      clear_frame();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings; directed cases first
      line_idle_pct = 15;
      rsp_idle_pct  = 15;
      push_line(8'h00);                 // ignored outside a frame
      push_line(8'hFF);
      push_line(FLAG_RESET);            // opens
      push_line(FLAG_RESET);            // empty frame stays open
      push_line(8'h11);
      push_line(8'h22);
      push_line(8'h33);
      push_line(FLAG_RESET);            // too short, reopens
      push_line(ESCAPE_RESET);          // escape after escape
      push_line(ESCAPE_RESET);
      push_line(8'h5E);
      push_line(ESCAPE_RESET);          // escaped flag still delimits
      push_line(FLAG_RESET);
      frame_body = '{8'h00, 8'hFF, 8'h7E, 8'h7D, 8'hA5};
      queue_frame(1'b0);
      queue_traffic(40);
      wait_drained();

      // zero flag, polynomial and start, all-ones escape; one frame spans a crc_start write
      configure(8'h00, 8'hFF, 16'h0000, 16'h0000);
      line_idle_pct = 0;
      rsp_idle_pct  = 25;
      queue_traffic(40);
      mark = line_bytes.size();
      fill_body(12);
      queue_frame(1'b0);
      while (line_bytes.size() > mark + 7) carry_bytes.push_front(line_bytes.pop_back());
      wait_drained();
      write_csr(CSR_CRC_START, 16'hBEEF);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      line_bytes = {line_bytes, carry_bytes};
      queue_traffic(20);
      wait_drained();

      // all-ones flag, polynomial and start, zero escape
      configure(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF);
      line_idle_pct = 25;
      rsp_idle_pct  = 0;
      queue_traffic(40);
      wait_drained();

      // other polynomial, plus one oversize frame
      configure(FLAG_RESET, ESCAPE_RESET, 16'h8408, 16'hFFFF);
      line_idle_pct = 10;
      rsp_idle_pct  = 10;
      fill_body(MAX_FRAME_BYTES - 1);
      queue_frame(1'b0);
      queue_traffic(20);
      wait_drained();

      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      line_idle_pct = 30;
      rsp_idle_pct  = 30;
      queue_traffic(40);
      wait_drained();

      // escaping the escape value produces the flag
      configure(8'h5D, 8'h7D, 16'hA001, 16'h1D0F);
      line_idle_pct = 5;
      rsp_idle_pct  = 20;
      queue_traffic(40);
      wait_drained();

      // back to reset settings, full rate both sides
      configure(FLAG_RESET, ESCAPE_RESET, POLY_RESET, START_RESET);
      line_idle_pct = 0;
      rsp_idle_pct  = 0;
      queue_traffic(60);
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("%0d line bytes over %0d register settings; results: %0d payload, %0d ok,",
               accepted_bytes, settings_used, kinds_seen[0], kinds_seen[1]);
      $display("%0d crc error, %0d too long, %0d too short; %0d mismatches",
               kinds_seen[2], kinds_seen[3], kinds_seen[4], errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ byte_stuffed_frame_receiver.f @@
rtl/bsfr_pkg.sv
rtl/bsfr_crc16.sv
rtl/bsfr_deframer.sv
rtl/byte_stuffed_frame_receiver.sv
tb/byte_stuffed_frame_receiver_test.sv
